/* sv/ngh_pkg.sv */
// Shared types, constants and codes of the noise gate with hold and hysteresis.
package ngh_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 16;
    localparam int HOLD_W       = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int BLOCK_LEN_DEF = 48;

    // Shared multiplier: 32-bit signed by 17-bit signed operand.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Output scaling drops 30 fraction bits (two Q1.15 factors).
    localparam int OUT_SHIFT = 30;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OPEN_TH      = 3'd0,
        REG_CLOSE_TH     = 3'd1,
        REG_ATTACK_STEP  = 3'd2,
        REG_RELEASE_STEP = 3'd3,
        REG_HOLD_BLOCKS  = 3'd4,
        REG_FLOOR_GAIN   = 3'd5,
        REG_DRY_GAIN     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] open_th;
        logic [GAIN_W-1:0] close_th;
        logic [GAIN_W-1:0] attack_step;
        logic [GAIN_W-1:0] release_step;
        logic [HOLD_W-1:0] hold_blocks;
        logic [GAIN_W-1:0] floor_gain;
        logic [GAIN_W-1:0] dry_gain;
    } t_cfg;

    typedef struct packed {
        logic sample_en;   // fold a new detector magnitude into the block
        logic block_en;    // apply the block-end gate update if one is pending
    } t_gate_ctl;

endpackage

/* sv/ngh_in_if.sv */
// Input channel: stereo sample pair and sidechain detector sample.
interface ngh_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic signed [15:0] detector_sample;

    modport source (output valid, left_sample, right_sample, detector_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, detector_sample, output ready);
    modport mon    (input valid, ready, left_sample, right_sample, detector_sample);
endinterface

/* sv/ngh_out_if.sv */
// Output channel: gated mono sample and the gain applied to it.
interface ngh_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] gated_sample;
    logic        [15:0] current_gain;

    modport source (output valid, gated_sample, current_gain, input ready);
    modport sink   (input valid, gated_sample, current_gain, output ready);
    modport mon    (input valid, ready, gated_sample, current_gain);
endinterface

/* sv/ngh_cfg_regs.sv */
// Configuration register file with its write port.
module ngh_cfg_regs
    import ngh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_idx,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_th      <= '0;
            r_cfg.close_th     <= '0;
            r_cfg.attack_step  <= GAIN_UNITY;
            r_cfg.release_step <= GAIN_UNITY;
            r_cfg.hold_blocks  <= '0;
            r_cfg.floor_gain   <= '0;
            r_cfg.dry_gain     <= GAIN_UNITY;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_idx))
                REG_OPEN_TH:      r_cfg.open_th      <= i_wr_data[GAIN_W-1:0];
                REG_CLOSE_TH:     r_cfg.close_th     <= i_wr_data[GAIN_W-1:0];
                REG_ATTACK_STEP:  r_cfg.attack_step  <= i_wr_data[GAIN_W-1:0];
                REG_RELEASE_STEP: r_cfg.release_step <= i_wr_data[GAIN_W-1:0];
                REG_HOLD_BLOCKS:  r_cfg.hold_blocks  <= i_wr_data[HOLD_W-1:0];
                REG_FLOOR_GAIN:   r_cfg.floor_gain   <= i_wr_data[GAIN_W-1:0];
                REG_DRY_GAIN:     r_cfg.dry_gain     <= i_wr_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/ngh_gate_ctrl.sv */
// Block peak tracker, hold counter and gate gain update.
module ngh_gate_ctrl
    import ngh_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_gate_ctl         i_ctl,
    input  logic [GAIN_W-1:0] i_mag,
    input  t_cfg              i_cfg,
    output logic [GAIN_W-1:0] o_gain
);

    localparam int CNT_W = $clog2(BLOCK_LEN + 1);

    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [GAIN_W-1:0] r_peak, n_peak;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic              r_blk,  n_blk;

    logic [CNT_W:0]    cnt_inc;
    logic [GAIN_W-1:0] flr;
    logic [GAIN_W:0]   gain_up;
    logic [GAIN_W-1:0] gain_open;
    logic [HOLD_W-1:0] hold_open;
    logic [HOLD_W-1:0] hold_dec;
    logic signed [GAIN_W+1:0] gain_dn;
    logic              is_open;

    always_comb begin
        cnt_inc = {1'b0, r_cnt} + {{CNT_W{1'b0}}, 1'b1};
        flr     = (i_cfg.floor_gain > GAIN_UNITY) ? GAIN_UNITY : i_cfg.floor_gain;
        is_open = (r_peak > i_cfg.open_th);

        gain_up   = {1'b0, r_gain} + {1'b0, i_cfg.attack_step};
        gain_open = r_gain;
        hold_open = r_hold;
        if (is_open) begin
            gain_open = (gain_up > {1'b0, GAIN_UNITY}) ? GAIN_UNITY : gain_up[GAIN_W-1:0];
            hold_open = i_cfg.hold_blocks;
        end
        hold_dec = (hold_open != '0) ? hold_open - 1'b1 : hold_open;
        gain_dn  = $signed({2'b00, gain_open}) - $signed({2'b00, i_cfg.release_step});

        n_cnt  = r_cnt;
        n_peak = r_peak;
        n_hold = r_hold;
        n_gain = r_gain;
        n_blk  = r_blk;
        if (i_ctl.sample_en) begin
            n_peak = (i_mag > r_peak) ? i_mag : r_peak;
            n_cnt  = cnt_inc[CNT_W-1:0];
            n_blk  = (cnt_inc >= (CNT_W+1)'(BLOCK_LEN));
        end else if (i_ctl.block_en && r_blk) begin
            n_hold = hold_dec;
            n_gain = gain_open;
            if (r_peak < i_cfg.close_th && hold_dec == '0) begin
                n_gain = (gain_dn <= $signed({2'b00, flr})) ? flr : gain_dn[GAIN_W-1:0];
            end
            n_peak = '0;
            n_cnt  = '0;
            n_blk  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_peak <= '0;
            r_hold <= '0;
            r_gain <= '0;
            r_blk  <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_peak <= n_peak;
            r_hold <= n_hold;
            r_gain <= n_gain;
            r_blk  <= n_blk;
        end
    end

    assign o_gain = r_gain;

endmodule

/* sv/ngh_mul.sv */
// Shared signed multiplier with a registered product.
module ngh_mul
    import ngh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

/* sv/noise_gate_hold_hysteresis.sv */
// Noise gate with hysteresis and hold: top level with the item sequencer.
//
// Usage: each input word on i_in carries a stereo pair and a filtered sidechain
// sample. The sidechain magnitude feeds a block peak; every BLOCK_LEN words the
// gate gain steps up by the attack step (peak above the open threshold, hold
// reloaded) or down by the release step toward the floor (peak below the close
// threshold once hold has run out). Each input word yields one output word on
// o_out: the mono mix times gate gain times dry gain, rounded and saturated,
// together with the gain that was applied.
// Configuration is written through the i_cfg_wr_* port while no word is in work.
// Sequence: the cycle after acceptance runs the gate update (S_UPD), then the
// single shared multiplier forms mix*gain (S_MUL1) and product*dry (S_MUL2),
// and S_OUT loads the output register once it is free. That multiplier sets
// the rate; i_in.ready is high while idle and in S_OUT once the output
// register is free, so a new word is accepted only as the last one is loaded.
// If the receiver stalls, the output register holds its word; the next result
// waits in the sequencer and i_in.ready stays low until the register frees.
// Synchronous reset clears the gate state and o_out.valid, returns the sequencer to idle and loads the config defaults.
module noise_gate_hold_hysteresis
    import ngh_pkg::*;
#(
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ngh_in_if.sink                i_in,
    ngh_out_if.source             o_out,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    typedef enum logic [2:0] {S_IDLE, S_UPD, S_MUL1, S_MUL2, S_OUT} t_state;

    localparam int Q_W = MUL_P_W - OUT_SHIFT;
    localparam logic [MUL_P_W-1:0] RND_HALF = MUL_P_W'(1) << (OUT_SHIFT - 1);

    t_state r_state;
    logic   r_out_valid;
    logic signed [SAMPLE_W-1:0] r_gated;
    logic        [GAIN_W-1:0]   r_gain_out;
    logic signed [SAMPLE_W-1:0] r_mix;

    t_cfg      cfg;
    t_gate_ctl gate_ctl;
    logic [GAIN_W-1:0] gain;
    logic              out_free;
    logic              out_load;
    logic              in_acc;
    logic signed [SAMPLE_W:0]   lr_sum;
    logic signed [SAMPLE_W:0]   det_abs;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [MUL_P_W-1:0]  p_rnd;
    logic signed [Q_W-1:0]      q;
    logic signed [SAMPLE_W-1:0] q_sat;

    ngh_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_wr_idx  (i_cfg_wr_idx),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (cfg)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = (r_state == S_OUT) && out_free;
    assign i_in.ready = (r_state == S_IDLE) || out_load;
    assign in_acc = i_in.valid && i_in.ready;

    // Magnitude of the detector sample; the most negative value maps to 32768.
    assign det_abs = i_in.detector_sample[SAMPLE_W-1]
                   ? -$signed({i_in.detector_sample[SAMPLE_W-1], i_in.detector_sample})
                   :  $signed({i_in.detector_sample[SAMPLE_W-1], i_in.detector_sample});

    assign gate_ctl.sample_en = in_acc;
    assign gate_ctl.block_en  = (r_state == S_UPD);

    ngh_gate_ctrl #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gate_ctl),
        .i_mag   (det_abs[GAIN_W-1:0]),
        .i_cfg   (cfg),
        .o_gain  (gain)
    );

    // First pass forms mix*gain, second pass scales that by the dry gain.
    always_comb begin
        if (r_state == S_MUL2) begin
            mul_a = mul_p[MUL_A_W-1:0];
            mul_b = $signed({1'b0, cfg.dry_gain});
        end else begin
            mul_a = MUL_A_W'(r_mix);
            mul_b = $signed({1'b0, gain});
        end
    end

    ngh_mul u_mul (
        .i_clk (i_clk),
        .i_en  ((r_state == S_MUL1) || (r_state == S_MUL2)),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Adding half an LSB and dropping 30 bits equals a floor shift of the
    // product rounded to nearest with ties toward plus infinity.
    always_comb begin
        p_rnd = mul_p + $signed(RND_HALF);
        q = p_rnd[MUL_P_W-1:OUT_SHIFT];
        if (q > $signed(Q_W'(32767))) begin
            q_sat = 16'sh7FFF;
        end else if (q < -$signed(Q_W'(32768))) begin
            q_sat = -16'sh8000;
        end else begin
            q_sat = q[SAMPLE_W-1:0];
        end
    end

    // Mono mix rounded toward minus infinity.
    assign lr_sum = $signed({i_in.left_sample[SAMPLE_W-1], i_in.left_sample})
                  + $signed({i_in.right_sample[SAMPLE_W-1], i_in.right_sample});

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mix <= lr_sum[SAMPLE_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD:  r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_gated     <= q_sat;
                        r_gain_out  <= gain;
                        r_state     <= in_acc ? S_UPD : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.gated_sample = r_gated;
    assign o_out.current_gain = r_gain_out;

endmodule

/* sv/ngh_checker.sv */
// Port-level checks of the noise gate, bound to the top level.
module ngh_checker
    import ngh_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [SAMPLE_W-1:0] i_out_sample,
    input logic [GAIN_W-1:0]   i_out_gain
);

    // A reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // The gain never exceeds unity.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_gain <= GAIN_UNITY))
        else $error("gain above unity");

    // An accepted word keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after accepting a word");

    // A stalled result holds its word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_sample) && $stable(i_out_gain)))
        else $error("stalled output changed");

endmodule

bind noise_gate_hold_hysteresis ngh_checker u_ngh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.gated_sample),
    .i_out_gain   (o_out.current_gain)
);
